[hw/rtl/lbp_pkg.sv]
// lbp_pkg: shared types, codes and helpers for the LSB-first bit packer.
// No dependencies; imported by every lbp_* module and by the top level.
package lbp_pkg;

  // Accumulator: at most 15 held bits plus one 8-bit digit.
  localparam int ACC_W     = 24;
  localparam int ACC_CNT_W = 5;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_FLUSH = 2'd1;
  localparam logic [1:0] FUNC_PAD   = 2'd2;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Alignment masks for pad length
  localparam logic [3:0] BYTE_ALIGN_MASK = 4'h7;
  localparam logic [3:0] WORD_ALIGN_MASK = 4'hF;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] write_value;
    logic [6:0]  write_count;
    logic [15:0] pad_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        status;
    logic [31:0] total_bits;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic emit_go;
  } acc_ctrl_t;

  typedef struct packed {
    logic       emit_rdy;
    logic [7:0] emit_byte;
    logic [3:0] pend_count;
  } acc_stat_t;

  typedef struct packed {
    logic        push;
    logic        finish;
    logic        status;
    logic [31:0] total_bits;
  } out_ctrl_t;

  typedef struct packed {
    logic can_push;
    logic can_finish;
  } out_stat_t;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7 - i];
    end
    return r;
  endfunction

endpackage

[hw/rtl/lbp_digit_src.sv]
// lbp_digit_src: field shift register; one masked byte digit a cycle on take.
// Depends on lbp_pkg (imported for house consistency).
module lbp_digit_src #(
  parameter int FIELD_W = 64,
  parameter int CNT_W   = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [FIELD_W-1:0] load_value,
  input  logic [CNT_W-1:0]   load_count,
  input  logic               take,
  output logic [7:0]         digit,
  output logic [3:0]         digit_bits
);
  import lbp_pkg::*;

  logic [FIELD_W-1:0] fsr;
  logic [CNT_W-1:0]   rem;

  always_comb begin
    digit_bits = (rem >= CNT_W'(8)) ? 4'd8 : 4'(rem);
    digit      = fsr[7:0] & ~(8'hFF << digit_bits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= load_count;
    end else if (take) begin
      rem <= rem - CNT_W'(digit_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fsr <= load_value;
    end else if (take) begin
      fsr <= fsr >> 8;
    end
  end

endmodule

[hw/rtl/lbp_accum.sv]
// lbp_accum: pending-bit accumulator; absorbs digits at the top, emits bytes at the bottom.
// Depends on lbp_pkg for widths, control/status structs and reverse8.
module lbp_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  lbp_pkg::acc_ctrl_t ctrl,
  input  logic [7:0]         digit,
  input  logic [3:0]         digit_bits,
  output logic               digit_take,
  output lbp_pkg::acc_stat_t stat
);
  import lbp_pkg::*;

  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     acc_emit;
  logic [ACC_W-1:0]     acc_next;
  logic [ACC_CNT_W-1:0] n;
  logic [ACC_CNT_W-1:0] n_emit;
  logic [ACC_CNT_W-1:0] n_next;
  logic                 half;
  logic                 half_next;
  logic [3:0]           k;
  logic [3:0]           k_next;
  logic                 drop;

  always_comb begin
    // drop bits once a byte (byte mode) or a whole word (second half) leaves
    drop     = ctrl.emit_go && (!mode || half);
    acc_emit = acc;
    n_emit   = n;
    if (drop) begin
      if (mode) begin
        acc_emit = acc >> 16;
        n_emit   = n - ACC_CNT_W'(16);
      end else begin
        acc_emit = acc >> 8;
        n_emit   = n - ACC_CNT_W'(8);
      end
    end

    digit_take = (digit_bits != 4'd0) && (n_emit <= ACC_CNT_W'(15));
    acc_next   = acc_emit;
    n_next     = n_emit;
    if (digit_take) begin
      acc_next = acc_emit | (ACC_W'(digit) << n_emit);
      n_next   = n_emit + ACC_CNT_W'(digit_bits);
    end

    half_next = half;
    k_next    = k;
    if (ctrl.start) begin
      half_next = 1'b0;
      k_next    = 4'd0;
    end else if (ctrl.emit_go) begin
      if (mode) begin
        half_next = !half;
      end else begin
        k_next = k + 4'd1;
      end
    end

    stat.emit_rdy   = mode ? (n >= ACC_CNT_W'(16))
                           : ((n >= ACC_CNT_W'(8)) && (k < 4'd8));
    stat.emit_byte  = mode ? (half ? reverse8(acc[7:0]) : reverse8(acc[15:8]))
                           : acc[7:0];
    stat.pend_count = n[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      n    <= '0;
      half <= 1'b0;
      k    <= 4'd0;
    end else begin
      acc  <= acc_next;
      n    <= n_next;
      half <= half_next;
      k    <= k_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= ACC_CNT_W'(23))
    else $error("accumulator holds more bits than it can");
  a_half_word: assert property (@(posedge clk) disable iff (rst)
    half |-> (mode && (n >= ACC_CNT_W'(16))))
    else $error("second half of a word pending without a full word held");
`endif

endmodule

[hw/rtl/lbp_out_stage.sv]
// lbp_out_stage: one-byte hold stage plus output register; marks the last item of a run.
// Depends on lbp_pkg for the output item and control/status structs.
module lbp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  lbp_pkg::out_ctrl_t ctrl,
  input  logic [7:0]         push_byte,
  input  logic               out_ready,
  output logic               out_valid,
  output lbp_pkg::out_item_t out_item,
  output lbp_pkg::out_stat_t stat
);
  import lbp_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       out_free;

  always_comb begin
    out_free        = !out_valid || out_ready;
    stat.can_push   = !hold_valid || out_free;
    stat.can_finish = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid  <= 1'b1;
      hold_valid <= 1'b0;
    end else if (ctrl.push) begin
      hold_valid <= 1'b1;
      if (hold_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      hold_byte <= push_byte;
    end
    if (ctrl.finish) begin
      out_item.data_byte   <= hold_valid ? hold_byte : 8'd0;
      out_item.byte_valid  <= hold_valid;
      out_item.last_of_run <= 1'b1;
      out_item.status      <= ctrl.status;
      out_item.total_bits  <= ctrl.total_bits;
    end else if (ctrl.push && hold_valid) begin
      out_item.data_byte   <= hold_byte;
      out_item.byte_valid  <= 1'b1;
      out_item.last_of_run <= 1'b0;
      out_item.status      <= ctrl.status;
      out_item.total_bits  <= ctrl.total_bits;
    end
  end

endmodule

[hw/rtl/lsb_first_bit_packer.sv]
// lsb_first_bit_packer: top level of the LSB-first bit packer (deflate-style bit writer).
// Depends on lbp_pkg, lbp_digit_src, lbp_accum and lbp_out_stage.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------------
//   input    | in_valid / in_ready   | in_item  (func, write_value, count, pad)
//   output   | out_valid / out_ready | out_item (byte, byte_valid, last, status, total)
//   config   | cfg_wr_en (no wait)   | cfg_wr_data (word16_reversed_mode)
//
// Flow: one item at a time; the next can be accepted once a run's last result is
// registered. Up to 8 bits enter and one byte leaves per cycle while the accumulator
// has room and the output is not stalled.
// Reset (rst, synchronous) clears the mode, pending bits and the running count.
// A stalled output holds the pipeline; the last item of a run can wait in the output.
module lsb_first_bit_packer #(
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbp_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output lbp_pkg::out_item_t out_item
);
  import lbp_pkg::*;

  localparam int         CNT_W   = $clog2(MAX_FIELD_BITS + 1);
  localparam logic [6:0] MAX_CNT = 7'(MAX_FIELD_BITS);

  state_t                    state;
  state_t                    state_next;
  logic                      mode;
  logic                      status;
  logic                      status_next;
  logic [31:0]               bits_written;
  logic                      in_acc;
  logic                      finish;
  logic [MAX_FIELD_BITS-1:0] load_value;
  logic [CNT_W-1:0]          load_count;
  logic [3:0]                plen_flush;
  logic [3:0]                plen_byte;
  logic [6:0]                clamped_count;
  logic [7:0]                digit;
  logic [3:0]                digit_bits;
  logic                      digit_take;
  acc_ctrl_t                 acc_ctrl;
  acc_stat_t                 acc_stat;
  out_ctrl_t                 out_ctrl;
  out_stat_t                 out_stat;

  // Decode the accepted operation into a field for the digit source.
  always_comb begin
    plen_flush    = (4'd0 - acc_stat.pend_count) & (mode ? WORD_ALIGN_MASK : BYTE_ALIGN_MASK);
    plen_byte     = (4'd0 - acc_stat.pend_count) & BYTE_ALIGN_MASK;
    clamped_count = (in_item.write_count > MAX_CNT) ? MAX_CNT : in_item.write_count;
    load_value    = '0;
    load_count    = '0;
    status_next   = STATUS_OK;
    case (in_item.func)
      FUNC_WRITE: begin
        load_value = in_item.write_value[MAX_FIELD_BITS-1:0];
        load_count = CNT_W'(clamped_count);
      end
      FUNC_FLUSH: begin
        // pad pattern; the digit mask keeps only plen bits
        load_value = MAX_FIELD_BITS'(in_item.pad_bits);
        load_count = CNT_W'(plen_flush);
      end
      FUNC_PAD: begin
        if (mode) begin
          status_next = STATUS_REFUSED;
        end else begin
          load_count = CNT_W'(plen_byte);
        end
      end
      default: begin
        // unused code: loads no bits; only bytes already pending can leave
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    in_acc   = in_valid && in_ready;

    acc_ctrl.start   = in_acc;
    acc_ctrl.emit_go = (state == ST_RUN) && acc_stat.emit_rdy && out_stat.can_push;

    // close the run once no digit is left, no byte can be emitted and the output is free
    finish = (state == ST_RUN) && (digit_bits == 4'd0) && !acc_stat.emit_rdy
             && out_stat.can_finish;

    out_ctrl.push       = acc_ctrl.emit_go;
    out_ctrl.finish     = finish;
    out_ctrl.status     = status;
    out_ctrl.total_bits = bits_written;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mode         <= 1'b0;
      status       <= STATUS_OK;
      bits_written <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if (in_acc) begin
        status       <= status_next;
        bits_written <= bits_written + 32'(load_count);
      end
    end
  end

  lbp_digit_src #(
    .FIELD_W (MAX_FIELD_BITS),
    .CNT_W   (CNT_W)
  ) u_digit_src (
    .clk        (clk),
    .rst        (rst),
    .load       (in_acc),
    .load_value (load_value),
    .load_count (load_count),
    .take       (digit_take),
    .digit      (digit),
    .digit_bits (digit_bits)
  );

  lbp_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .ctrl       (acc_ctrl),
    .digit      (digit),
    .digit_bits (digit_bits),
    .digit_take (digit_take),
    .stat       (acc_stat)
  );

  lbp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (out_ctrl),
    .push_byte (acc_stat.emit_byte),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (out_stat)
  );

`ifndef NO_ASSERTIONS
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !acc_ctrl.emit_go)
    else $error("byte emitted outside a run");
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && out_item.last_of_run))
    else $error("run closed without a last item");
  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    (finish && (status == STATUS_REFUSED)) |=> !out_item.byte_valid)
    else $error("refused pad produced a byte");
`endif

endmodule

[sim/lsb_first_bit_packer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lsb_first_bit_packer: directed and random items in both modes.
// Depends on lbp_pkg and the lsb_first_bit_packer RTL; a built-in bit packer predicts every byte.

module lsb_first_bit_packer_tb;
  import lbp_pkg::*;

  localparam int         MAX_FIELD      = 64;
  localparam logic [1:0] FUNC_UNUSED    = 2'd3;  // no operation behind this code
  localparam int         DRAIN_WAIT     = 16;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         STALL_LIMIT    = 4000;
  localparam int         RAND_PER_PHASE = 45;
  localparam int         REPORT_MAX     = 10;

  logic      clk         = 1'b0;
  logic      rst         = 1'b1;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_item     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_item;

  // Mirror of the block: pending bits, their count, running total and mode
  logic [15:0] mir_bits;
  logic [3:0]  mir_count;
  logic [31:0] mir_total;
  logic        mir_word_mode;
  logic [7:0]  done_bytes[$];   // bytes completed by the item being packed
  out_item_t   stream_q[$];     // results still owed by the block, oldest first

  int  mismatches    = 0;
  int  items_in      = 0;
  int  results_out   = 0;
  int  idle_cycles   = 0;
  int  src_idle_pct  = 0;
  int  snk_stall_pct = 0;
  logic hold_req     = 1'b0;

  lsb_first_bit_packer #(
    .MAX_FIELD_BITS(MAX_FIELD)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] flip16(logic [15:0] w);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = w[15 - i];
    end
    return r;
  endfunction

  // Add one completed byte to the current item's list.
  function automatic void keep_byte(logic [7:0] b);
    done_bytes.insert(done_bytes.size(), b);
  endfunction

  // Add one expected result at the tail of the owed stream.
  function automatic void owe_result(out_item_t r);
    stream_q.insert(stream_q.size(), r);
  endfunction

  // Append cnt bits of val above the pending bits and collect what is complete.
  function automatic void append_field(logic [63:0] val, int unsigned cnt);
    logic [79:0] acc;
    int unsigned n;
    logic [15:0] w;
    if (cnt > MAX_FIELD) cnt = MAX_FIELD;
    if (cnt < 64) val &= (64'd1 << cnt) - 64'd1;
    mir_total += cnt;
    acc = {64'd0, mir_bits} | ({16'd0, val} << mir_count);
    n = mir_count + cnt;
    if (mir_word_mode) begin
      // whole 16-bit words leave bit-reversed, low byte first
      while (n >= 16) begin
        w = flip16(acc[15:0]);
        keep_byte(w[7:0]);
        keep_byte(w[15:8]);
        acc >>= 16;
        n -= 16;
      end
    end else begin
      // at most eight bytes per item; any further byte stays pending
      while (n >= 8 && done_bytes.size() < 8) begin
        keep_byte(acc[7:0]);
        acc >>= 8;
        n -= 8;
      end
    end
    mir_bits  = acc[15:0];
    mir_count = n[3:0];
  endfunction

  // Work out every result one accepted item causes and queue them.
  function automatic void pack_item(in_item_t it);
    logic        st;
    int unsigned plen;
    out_item_t   r;
    done_bytes.delete();
    st = STATUS_OK;
    case (it.func)
      FUNC_WRITE: append_field(it.write_value, it.write_count);
      FUNC_FLUSH: begin
        plen = (16 - mir_count) & (mir_word_mode ? WORD_ALIGN_MASK : BYTE_ALIGN_MASK);
        append_field({48'd0, it.pad_bits}, plen);
      end
      FUNC_PAD: begin
        if (mir_word_mode) st = STATUS_REFUSED;
        else append_field(64'd0, (16 - mir_count) & BYTE_ALIGN_MASK);
      end
      default: ;
    endcase
    if (done_bytes.size() == 0) begin
      // nothing left the packer: one empty result closes the run
      r             = '0;
      r.last_of_run = 1'b1;
      r.status      = st;
      r.total_bits  = mir_total;
      owe_result(r);
    end else begin
      foreach (done_bytes[i]) begin
        r.data_byte   = done_bytes[i];
        r.byte_valid  = 1'b1;
        r.last_of_run = (i == done_bytes.size() - 1);
        r.status      = st;
        r.total_bits  = mir_total;
        owe_result(r);
      end
    end
  endfunction

  // Check each result, predict each accepted item, track the mode, watch for a hang.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      mir_bits      = '0;
      mir_count     = '0;
      mir_total     = '0;
      mir_word_mode = 1'b0;
      stream_q.delete();
      idle_cycles   = 0;
    end else begin
      idle_cycles++;
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        results_out++;
        if (stream_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: byte %02h valid %0d last %0d status %0d total %0d",
                     out_item.data_byte, out_item.byte_valid, out_item.last_of_run,
                     out_item.status, out_item.total_bits);
        end else begin
          want = stream_q.pop_front();
          if (out_item.data_byte !== want.data_byte || out_item.byte_valid !== want.byte_valid ||
              out_item.last_of_run !== want.last_of_run || out_item.status !== want.status ||
              out_item.total_bits !== want.total_bits) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result %0d: exp byte %02h valid %0d last %0d status %0d total %0d",
                       results_out, want.data_byte, want.byte_valid, want.last_of_run,
                       want.status, want.total_bits,
                       " / got byte %02h valid %0d last %0d status %0d total %0d",
                       out_item.data_byte, out_item.byte_valid, out_item.last_of_run,
                       out_item.status, out_item.total_bits);
          end
        end
      end
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        items_in++;
        pack_item(in_item);
      end
      if (cfg_wr_en) mir_word_mode = cfg_wr_data;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, stream_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: decide at the rising edge, drive at the falling edge.
  // A hold request keeps out_ready low until its countdown, loaded from HOLD_CYCLES, runs out.
  always begin : receiver
    int   hold_left;
    logic rdy_next;
    @(posedge clk);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy_next = 1'b0;
    end else begin
      rdy_next = ($urandom_range(99) >= snk_stall_pct);
    end
    @(negedge clk);
    out_ready <= rdy_next;
  end

  function automatic in_item_t mk(logic [1:0] f, logic [63:0] v, logic [6:0] c, logic [15:0] p);
    in_item_t r;
    r.func        = f;
    r.write_value = v;
    r.write_count = c;
    r.pad_bits    = p;
    return r;
  endfunction

  // Mostly writes; counts above the maximum, flushes, pads and the unused code mixed in.
  function automatic in_item_t rand_item();
    int unsigned sel;
    logic [1:0]  f;
    logic [6:0]  c;
    logic [63:0] v;
    sel = $urandom_range(99);
    if (sel < 68)      f = FUNC_WRITE;
    else if (sel < 80) f = FUNC_FLUSH;
    else if (sel < 93) f = FUNC_PAD;
    else               f = FUNC_UNUSED;
    case ($urandom_range(9))
      0:       c = 7'd0;
      1:       c = 7'd64;
      2:       c = 7'($urandom_range(65, 127));
      default: c = 7'($urandom_range(1, 63));
    endcase
    v = ($urandom_range(9) == 0) ? '1 : {$urandom, $urandom};
    return mk(f, v, c, 16'($urandom));
  endfunction

  // Offer one item after a random gap and hold it until accepted; return at a falling edge.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic settle();
    in_valid <= 1'b0;
    while (stream_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_mode(logic word_mode);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= word_mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Byte mode: field extremes, clamped counts, flush with and without bits pending, and pad.
  task automatic test_byte_mode();
    set_mode(1'b0);
    send_item(mk(FUNC_WRITE, '1, 7'd0, 16'h0000));       // empty field, value masked off
    send_item(mk(FUNC_WRITE, 64'd1, 7'd1, 16'h0000));
    send_item(mk(FUNC_WRITE, '1, 7'd7, 16'h0000));       // completes one byte
    send_item(mk(FUNC_WRITE, '1, 7'd64, 16'hFFFF));      // eight bytes at once
    send_item(mk(FUNC_WRITE, 64'h5, 7'd3, 16'h0000));
    send_item(mk(FUNC_FLUSH, 64'd0, 7'd0, 16'hFFFF));    // pad five bits
    send_item(mk(FUNC_FLUSH, '1, 7'd0, 16'h0000));       // already aligned: empty
    send_item(mk(FUNC_WRITE, {$urandom, $urandom}, 7'd127, 16'h0000));  // clamp to max
    send_item(mk(FUNC_WRITE, '1, 7'd65, 16'h0000));
    send_item(mk(FUNC_WRITE, 64'hABC, 7'd12, 16'h0000));
    send_item(mk(FUNC_PAD, '1, 7'd0, 16'hFFFF));         // zeros to the byte edge
    send_item(mk(FUNC_UNUSED, '1, 7'd64, 16'hFFFF));     // ignored: empty, status ok
  endtask

  // Word mode: reversed words, flush to 16 bits, pad refused, leave 15 bits pending.
  task automatic test_word_mode();
    set_mode(1'b1);
    send_item(mk(FUNC_WRITE, 64'h0001, 7'd16, 16'h0000));
    send_item(mk(FUNC_WRITE, 64'h5, 7'd3, 16'h0000));
    send_item(mk(FUNC_FLUSH, 64'd0, 7'd0, 16'hFFFF));    // thirteen pad bits
    send_item(mk(FUNC_WRITE, {$urandom, $urandom}, 7'd64, 16'h0000));
    send_item(mk(FUNC_PAD, 64'd0, 7'd0, 16'h0000));      // refused
    send_item(mk(FUNC_UNUSED, 64'd0, 7'd0, 16'h0000));
    send_item(mk(FUNC_WRITE, '1, 7'd15, 16'h0000));
  endtask

  // Change mode with bits pending: nine bytes ready in byte mode, only eight may leave.
  task automatic test_mode_switch();
    set_mode(1'b0);
    send_item(mk(FUNC_WRITE, {$urandom, $urandom}, 7'd64, 16'h0000));
    send_item(mk(FUNC_WRITE, 64'd0, 7'd0, 16'h0000));    // releases the held byte
    send_item(mk(FUNC_WRITE, 64'h1F, 7'd5, 16'h0000));
    set_mode(1'b1);
    send_item(mk(FUNC_WRITE, 64'($urandom), 7'd20, 16'h0000));
    send_item(mk(FUNC_FLUSH, 64'd0, 7'd0, 16'($urandom)));
  endtask

  // Random items in both modes under four idle mixes; the mode is written between runs.
  task automatic test_random_traffic();
    int src_mix[4] = '{0, 53, 0, 29};
    int snk_mix[4] = '{0, 0, 53, 29};
    for (int ph = 0; ph < 4; ph++) begin
      for (int m = 0; m < 2; m++) begin
        set_mode(m[0]);
        src_idle_pct  = src_mix[ph];
        snk_stall_pct = snk_mix[ph];
        repeat (RAND_PER_PHASE) send_item(rand_item());
      end
    end
  endtask

  // Hold the output off for a long stretch while full-width writes keep coming.
  task automatic test_output_hold();
    set_mode(1'b0);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b1;
    repeat (24) send_item(mk(FUNC_WRITE, {$urandom, $urandom}, 7'd64, 16'($urandom)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the 32-bit wrap of the running count is out of reach in a run this short
    test_byte_mode();
    test_word_mode();
    test_mode_switch();
    test_random_traffic();
    test_output_hold();
    settle();
    $display("Sent %0d items and checked %0d results: byte and reversed 16-bit modes,",
             items_in, results_out);
    $display("mode changes with bits pending, four idle mixes and one long output hold.");
    if (mismatches == 0 && stream_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_digit_src.sv
hw/rtl/lbp_accum.sv
hw/rtl/lbp_out_stage.sv
hw/rtl/lsb_first_bit_packer.sv
sim/lsb_first_bit_packer_tb.sv
